// File: rtl/bmhe_pkg.sv
// Package for the binary max-heap engine: word types, operation and status
// codes, and the command and status groups between controller and datapath.
// No dependencies.
`default_nettype none

package bmhe_pkg;

    localparam logic [2:0] FN_LOAD   = 3'd0;
    localparam logic [2:0] FN_CHECK  = 3'd1;
    localparam logic [2:0] FN_INSERT = 3'd2;
    localparam logic [2:0] FN_DELETE = 3'd3;
    localparam logic [2:0] FN_SORT   = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] value;
    } item_word_t;

    typedef struct packed {
        logic signed [31:0] data_out;
        logic [6:0]         entry_total;
        logic               heap_ok;
        logic [1:0]         status;
        logic               final_item;
    } result_word_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_START,
        OP_APPEND,
        OP_UP_INIT,
        OP_RD_PARENT,
        OP_UP_STEP,
        OP_WR_HOLE,
        OP_RD_L,
        OP_LATCH_L,
        OP_PICK_R,
        OP_DOWN_STEP,
        OP_CHK_INIT,
        OP_RD_PAR_CHK,
        OP_LATCH_P,
        OP_CHK_INC,
        OP_BLD_INIT,
        OP_RD_BLD,
        OP_LOAD_X_BLD,
        OP_RD_ROOT,
        OP_LATCH_TOP,
        OP_DEL_X,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] st;
        logic       ok;
        logic       fin;
        logic       use_top;
    } dp_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic cnt_zero;
        logic idx_gt1;
        logic l_gt_n;
        logic r_le_n;
        logic up_gt;
        logic dn_gt;
        logic chk_gt;
        logic chk_done;
        logic bld_zero;
    } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/binary_max_heap_engine.sv
// Top level of the binary max-heap engine: controller plus datapath.
// Depends on bmhe_pkg, bmhe_ctrl and bmhe_dp.
//
// A word is taken when start is high and busy is low; busy then stays high
// until the last result has been issued. Each result is shown for one cycle
// with strobe and cannot be stalled. The controller walks the heap memory,
// which has registered read data, and the result is registered. Load
// appends the word; insert sifts it up from a new last entry level by
// level; delete takes the root, moves the last entry to the root and sifts
// it down; check compares every entry after the root with its parent, and
// on the first parent smaller than a child it stops and runs a bottom-up
// build with a sift-down per parent node; sort is a build followed by a
// delete for every entry, each issued as a result. A sift-down descends
// one level at a time until it stops. No clearing pass is needed after
// reset.
`default_nettype none

module binary_max_heap_engine #(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire bmhe_pkg::item_word_t   item,
    output bmhe_pkg::result_word_t      result,
    output logic                        strobe
);

    bmhe_pkg::dp_cmd_t  cmd;
    bmhe_pkg::dp_stat_t stat;

    bmhe_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (item.func),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    bmhe_dp #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .value  (item.value),
        .cmd    (cmd),
        .stat   (stat),
        .result (result),
        .strobe (strobe)
    );

endmodule

`default_nettype wire

// File: rtl/bmhe_dp.sv
// Datapath of the heap engine: heap memory, entry count, walk indexes and
// the result register. Executes one command from bmhe_ctrl per cycle; uses bmhe_pkg.
`default_nettype none

module bmhe_dp #(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic signed [31:0]   value,
    input  wire bmhe_pkg::dp_cmd_t    cmd,
    output bmhe_pkg::dp_stat_t        stat,
    output bmhe_pkg::result_word_t    result,
    output logic                      strobe
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = CW + 1;
    localparam int AW = $clog2(CAPACITY);

    logic signed [VALUE_BITS-1:0] mem [CAPACITY];

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] cidx_reg, cidx_next;
    logic [CW-1:0] bld_reg, bld_next;
    logic [IW-1:0] chk_reg, chk_next;
    logic signed [VALUE_BITS-1:0] x_reg, x_next;
    logic signed [VALUE_BITS-1:0] c_reg, c_next;
    logic signed [VALUE_BITS-1:0] top_reg, top_next;
    logic signed [VALUE_BITS-1:0] rdata_reg;
    bmhe_pkg::result_word_t result_reg, result_next;
    logic strobe_reg, strobe_next;

    logic [IW-1:0] lidx, ridx, cnt_ext, rd_idx, rd_tmp;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [CW-1:0] idx_m1;
    logic signed [VALUE_BITS-1:0] wr_data;
    logic wr_en;
    logic signed [63:0] in64, out64;

    assign lidx    = {idx_reg, 1'b0};
    assign ridx    = {idx_reg, 1'b1};
    assign cnt_ext = {1'b0, count_reg};
    assign idx_m1  = idx_reg - CW'(1);
    assign in64    = 64'(value);
    assign out64   = 64'(top_reg);

    assign stat.full     = (count_reg == CW'(CAPACITY));
    assign stat.empty    = (count_reg == '0);
    assign stat.cnt_zero = (count_reg == '0);
    assign stat.idx_gt1  = (idx_reg > CW'(1));
    assign stat.l_gt_n   = (lidx > cnt_ext);
    assign stat.r_le_n   = (ridx <= cnt_ext);
    assign stat.up_gt    = (x_reg > rdata_reg);
    assign stat.dn_gt    = (c_reg > x_reg);
    assign stat.chk_gt   = (rdata_reg > c_reg);
    assign stat.chk_done = (chk_reg > cnt_ext);
    assign stat.bld_zero = (bld_reg == '0);

    always_comb
    begin
        case (cmd.op)
            bmhe_pkg::OP_RD_PARENT:  rd_idx = {2'b00, idx_reg[CW-1:1]};
            bmhe_pkg::OP_RD_L:       rd_idx = lidx;
            bmhe_pkg::OP_LATCH_L:    rd_idx = ridx;
            bmhe_pkg::OP_RD_PAR_CHK: rd_idx = {1'b0, chk_reg[IW-1:1]};
            bmhe_pkg::OP_LATCH_P:    rd_idx = chk_reg;
            bmhe_pkg::OP_RD_BLD:     rd_idx = {1'b0, bld_reg};
            bmhe_pkg::OP_LATCH_TOP:  rd_idx = cnt_ext;
            default:                 rd_idx = IW'(1);
        endcase
        rd_tmp  = rd_idx - IW'(1);
        rd_addr = rd_tmp[AW-1:0];
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = idx_m1[AW-1:0];
        wr_data = x_reg;
        case (cmd.op)
            bmhe_pkg::OP_APPEND:
            begin
                wr_en   = 1'b1;
                wr_addr = count_reg[AW-1:0];
            end
            bmhe_pkg::OP_UP_STEP:
            begin
                wr_en   = 1'b1;
                wr_data = stat.up_gt ? rdata_reg : x_reg;
            end
            bmhe_pkg::OP_WR_HOLE:   wr_en = 1'b1;
            bmhe_pkg::OP_DOWN_STEP:
            begin
                wr_en   = 1'b1;
                wr_data = stat.dn_gt ? c_reg : x_reg;
            end
            default:                wr_en = 1'b0;
        endcase
    end

    always_comb
    begin
        count_next  = count_reg;
        idx_next    = idx_reg;
        cidx_next   = cidx_reg;
        bld_next    = bld_reg;
        chk_next    = chk_reg;
        x_next      = x_reg;
        c_next      = c_reg;
        top_next    = top_reg;
        result_next = result_reg;
        strobe_next = 1'b0;
        case (cmd.op)
            bmhe_pkg::OP_START:     x_next = in64[VALUE_BITS-1:0];
            bmhe_pkg::OP_APPEND:    count_next = count_reg + CW'(1);
            bmhe_pkg::OP_UP_INIT:
            begin
                count_next = count_reg + CW'(1);
                idx_next   = count_reg + CW'(1);
            end
            bmhe_pkg::OP_UP_STEP:
                if (stat.up_gt)
                begin
                    idx_next = idx_reg >> 1;
                end
            bmhe_pkg::OP_LATCH_L:
            begin
                c_next    = rdata_reg;
                cidx_next = lidx[CW-1:0];
            end
            bmhe_pkg::OP_PICK_R:
                if (rdata_reg > c_reg)
                begin
                    c_next    = rdata_reg;
                    cidx_next = ridx[CW-1:0];
                end
            bmhe_pkg::OP_DOWN_STEP:
                if (stat.dn_gt)
                begin
                    idx_next = cidx_reg;
                end
            bmhe_pkg::OP_CHK_INIT:  chk_next = IW'(2);
            bmhe_pkg::OP_LATCH_P:   c_next = rdata_reg;
            bmhe_pkg::OP_CHK_INC:   chk_next = chk_reg + IW'(1);
            bmhe_pkg::OP_BLD_INIT:  bld_next = count_reg >> 1;
            bmhe_pkg::OP_LOAD_X_BLD:
            begin
                x_next   = rdata_reg;
                idx_next = bld_reg;
                bld_next = bld_reg - CW'(1);
            end
            bmhe_pkg::OP_LATCH_TOP: top_next = rdata_reg;
            bmhe_pkg::OP_DEL_X:
            begin
                x_next     = rdata_reg;
                idx_next   = CW'(1);
                count_next = count_reg - CW'(1);
            end
            bmhe_pkg::OP_EMIT:
            begin
                strobe_next             = 1'b1;
                result_next.data_out    = cmd.use_top ? out64[31:0] : 32'sd0;
                result_next.entry_total = 7'(count_reg);
                result_next.heap_ok     = cmd.ok;
                result_next.status      = cmd.st;
                result_next.final_item  = cmd.fin;
            end
            default:                x_next = x_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[rd_addr];
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        cidx_reg   <= cidx_next;
        bld_reg    <= bld_next;
        chk_reg    <= chk_next;
        x_reg      <= x_next;
        c_reg      <= c_next;
        top_reg    <= top_next;
        result_reg <= result_next;
    end

    assign result = result_reg;
    assign strobe = strobe_reg;

endmodule

`default_nettype wire

// File: rtl/bmhe_ctrl.sv
// Controller of the heap engine: sequences sift-up, sift-down, check, build
// and extraction as commands to bmhe_dp. Uses bmhe_pkg.
`default_nettype none

module bmhe_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [2:0]         func,
    input  wire bmhe_pkg::dp_stat_t stat,
    output bmhe_pkg::dp_cmd_t       cmd,
    output logic                    busy
);

    typedef enum logic [4:0] {
        S_IDLE, S_LOAD, S_UP_INIT, S_UP_CHK, S_UP_CMP,
        S_CHK_INIT, S_CHK_LOOP, S_CHK_P, S_CHK_C,
        S_BLD_INIT, S_BLD_LOOP, S_BLD_X,
        S_SD_CHK, S_SD_L, S_SD_R, S_SD_CMP,
        S_DEL_START, S_DEL_TOP, S_DEL_LAST, S_DEL_EMIT,
        S_EMIT_FULL, S_EMIT_EMPTY, S_EMIT_OK, S_EMIT_HEAP
    } state_t;

    state_t     state_reg, state_next;
    state_t     ret_reg, ret_next;
    logic [2:0] func_reg, func_next;

    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        func_next   = func_reg;
        cmd.op      = bmhe_pkg::OP_NONE;
        cmd.st      = bmhe_pkg::ST_OK;
        cmd.ok      = 1'b0;
        cmd.fin     = 1'b1;
        cmd.use_top = 1'b0;
        case (state_reg)
            S_IDLE:
                if (start)
                begin
                    cmd.op    = bmhe_pkg::OP_START;
                    func_next = func;
                    case (func)
                        bmhe_pkg::FN_LOAD:
                            state_next = stat.full ? S_EMIT_FULL : S_LOAD;
                        bmhe_pkg::FN_INSERT:
                            state_next = stat.full ? S_EMIT_FULL : S_UP_INIT;
                        bmhe_pkg::FN_CHECK:
                            state_next = stat.empty ? S_EMIT_EMPTY : S_CHK_INIT;
                        bmhe_pkg::FN_DELETE:
                            state_next = stat.empty ? S_EMIT_EMPTY : S_DEL_START;
                        bmhe_pkg::FN_SORT:
                            state_next = stat.empty ? S_EMIT_EMPTY : S_BLD_INIT;
                        default:
                            state_next = S_EMIT_OK;
                    endcase
                end
            S_LOAD:
            begin
                cmd.op     = bmhe_pkg::OP_APPEND;
                state_next = S_EMIT_OK;
            end
            S_UP_INIT:
            begin
                cmd.op     = bmhe_pkg::OP_UP_INIT;
                state_next = S_UP_CHK;
            end
            S_UP_CHK:
                if (stat.idx_gt1)
                begin
                    cmd.op     = bmhe_pkg::OP_RD_PARENT;
                    state_next = S_UP_CMP;
                end
                else
                begin
                    cmd.op     = bmhe_pkg::OP_WR_HOLE;
                    state_next = S_EMIT_OK;
                end
            S_UP_CMP:
            begin
                cmd.op     = bmhe_pkg::OP_UP_STEP;
                state_next = stat.up_gt ? S_UP_CHK : S_EMIT_OK;
            end
            S_CHK_INIT:
            begin
                cmd.op     = bmhe_pkg::OP_CHK_INIT;
                state_next = S_CHK_LOOP;
            end
            S_CHK_LOOP:
                if (stat.chk_done)
                begin
                    state_next = S_EMIT_HEAP;
                end
                else
                begin
                    cmd.op     = bmhe_pkg::OP_RD_PAR_CHK;
                    state_next = S_CHK_P;
                end
            S_CHK_P:
            begin
                cmd.op     = bmhe_pkg::OP_LATCH_P;
                state_next = S_CHK_C;
            end
            S_CHK_C:
            begin
                cmd.op     = bmhe_pkg::OP_CHK_INC;
                state_next = stat.chk_gt ? S_BLD_INIT : S_CHK_LOOP;
            end
            S_BLD_INIT:
            begin
                cmd.op     = bmhe_pkg::OP_BLD_INIT;
                state_next = S_BLD_LOOP;
            end
            S_BLD_LOOP:
                if (stat.bld_zero)
                begin
                    state_next = (func_reg == bmhe_pkg::FN_SORT) ? S_DEL_START : S_EMIT_OK;
                end
                else
                begin
                    cmd.op     = bmhe_pkg::OP_RD_BLD;
                    state_next = S_BLD_X;
                end
            S_BLD_X:
            begin
                cmd.op     = bmhe_pkg::OP_LOAD_X_BLD;
                ret_next   = S_BLD_LOOP;
                state_next = S_SD_CHK;
            end
            S_SD_CHK:
                if (stat.l_gt_n)
                begin
                    cmd.op     = bmhe_pkg::OP_WR_HOLE;
                    state_next = ret_reg;
                end
                else
                begin
                    cmd.op     = bmhe_pkg::OP_RD_L;
                    state_next = S_SD_L;
                end
            S_SD_L:
            begin
                cmd.op     = bmhe_pkg::OP_LATCH_L;
                state_next = stat.r_le_n ? S_SD_R : S_SD_CMP;
            end
            S_SD_R:
            begin
                cmd.op     = bmhe_pkg::OP_PICK_R;
                state_next = S_SD_CMP;
            end
            S_SD_CMP:
            begin
                cmd.op     = bmhe_pkg::OP_DOWN_STEP;
                state_next = stat.dn_gt ? S_SD_CHK : ret_reg;
            end
            S_DEL_START:
            begin
                cmd.op     = bmhe_pkg::OP_RD_ROOT;
                state_next = S_DEL_TOP;
            end
            S_DEL_TOP:
            begin
                cmd.op     = bmhe_pkg::OP_LATCH_TOP;
                state_next = S_DEL_LAST;
            end
            S_DEL_LAST:
            begin
                cmd.op     = bmhe_pkg::OP_DEL_X;
                ret_next   = S_DEL_EMIT;
                state_next = S_SD_CHK;
            end
            S_DEL_EMIT:
            begin
                cmd.op      = bmhe_pkg::OP_EMIT;
                cmd.use_top = 1'b1;
                cmd.fin     = (func_reg == bmhe_pkg::FN_DELETE) || stat.cnt_zero;
                state_next  = cmd.fin ? S_IDLE : S_DEL_START;
            end
            S_EMIT_FULL:
            begin
                cmd.op     = bmhe_pkg::OP_EMIT;
                cmd.st     = bmhe_pkg::ST_FULL;
                state_next = S_IDLE;
            end
            S_EMIT_EMPTY:
            begin
                cmd.op     = bmhe_pkg::OP_EMIT;
                cmd.st     = bmhe_pkg::ST_EMPTY;
                state_next = S_IDLE;
            end
            S_EMIT_HEAP:
            begin
                cmd.op     = bmhe_pkg::OP_EMIT;
                cmd.ok     = 1'b1;
                state_next = S_IDLE;
            end
            S_EMIT_OK:
            begin
                cmd.op     = bmhe_pkg::OP_EMIT;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_BLD_LOOP;
            func_reg  <= bmhe_pkg::FN_LOAD;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            func_reg  <= func_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

// File: rtl/bmhe_checker.sv
// Port-level checker for the heap engine, bound to the top level.
// Depends on bmhe_pkg.
`default_nettype none

module bmhe_checker (
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   start,
    input wire logic                   busy,
    input wire bmhe_pkg::result_word_t result,
    input wire logic                   strobe
);

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted word");

    a_more_results: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.final_item |-> busy)
        else $error("non-final result while engine idle");

    a_error_result: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.status != bmhe_pkg::ST_OK |->
            result.data_out == 32'sd0 && result.final_item && !result.heap_ok)
        else $error("error result carries data or is not final");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> result.status == bmhe_pkg::ST_OK || result.status == bmhe_pkg::ST_FULL
            || result.status == bmhe_pkg::ST_EMPTY)
        else $error("undefined status code");

    a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |=> !strobe)
        else $error("results in adjacent cycles");

endmodule

bind binary_max_heap_engine bmhe_checker u_bmhe_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .result (result),
    .strobe (strobe)
);

`default_nettype wire
